// ----- rtl/u2d_pkg.sv -----
`default_nettype none
package u2d_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [15:0] QMARK_CP   = 16'h003F;
   localparam logic [7:0]  QMARK_BYTE = 8'h3F;

   // one byte of the string
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   // one decoded character
   typedef struct packed {
      logic [15:0] code_point;
      logic        end_of_string;
   } rsp_type;

   // queue entry: one or two characters caused by one byte
   // second character, when present, always ends the string
   typedef struct packed {
      logic [15:0] first_cp;
      logic        first_eos;
      logic        has_second;
      logic [7:0]  second_cp;
   } qent_type;

   // front to queue push channel
   typedef struct packed {
      logic     valid;
      qent_type entry;
   } push_type;

endpackage
`default_nettype wire

// ----- rtl/u2d_front.sv -----
`default_nettype none
module u2d_front import u2d_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          req_stall,
   output push_type      push
);

   logic [7:0] pending_lead_ff,   pending_lead_in;
   logic [7:0] pending_second_ff, pending_second_in;
   logic [1:0] bytes_pending_ff,  bytes_pending_in;
   logic [1:0] bytes_needed_ff,   bytes_needed_in;

   logic       accept;
   logic [7:0] b;
   logic       last;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data.data_byte;
   assign last      = req_data.is_last;

   always_comb begin
      pending_lead_in   = pending_lead_ff;
      pending_second_in = pending_second_ff;
      bytes_pending_in  = bytes_pending_ff;
      bytes_needed_in   = bytes_needed_ff;
      push.valid            = 1'b0;
      push.entry.first_cp   = QMARK_CP;
      push.entry.first_eos  = last;
      push.entry.has_second = 1'b0;
      push.entry.second_cp  = QMARK_BYTE;

      if (bytes_pending_ff == 2'd0) begin
         if (b < 8'h80) begin
            push.valid          = accept;
            push.entry.first_cp = {8'h00, b};
         end else if ((b inside {[8'hC0:8'hDF]}) || (b inside {[8'hE0:8'hEF]})) begin
            if (last) begin
               // lead with nothing after it
               push.valid = accept;
            end else if (accept) begin
               pending_lead_in  = b;
               bytes_pending_in = 2'd1;
               bytes_needed_in  = (b inside {[8'hC0:8'hDF]}) ? 2'd1 : 2'd2;
            end
         end else begin
            // stray continuation or 4-byte lead
            push.valid = accept;
         end
      end else if (bytes_needed_ff == 2'd2) begin
         if (last) begin
            // cut three-byte sequence: lead gives '?', this byte decoded alone
            push.valid            = accept;
            push.entry.first_eos  = 1'b0;
            push.entry.has_second = 1'b1;
            push.entry.second_cp  = (b < 8'h80) ? b : QMARK_BYTE;
            if (accept) begin
               pending_lead_in   = 8'h00;
               pending_second_in = 8'h00;
               bytes_pending_in  = 2'd0;
               bytes_needed_in   = 2'd0;
            end
         end else if (accept) begin
            pending_second_in = b;
            bytes_pending_in  = 2'd2;
            bytes_needed_in   = 2'd1;
         end
      end else begin
         push.valid = accept;
         if (bytes_pending_ff >= 2'd2) begin
            push.entry.first_cp = {pending_lead_ff[3:0], pending_second_ff[5:0], b[5:0]};
         end else begin
            push.entry.first_cp = {5'b0, pending_lead_ff[4:0], b[5:0]};
         end
         if (accept) begin
            pending_lead_in   = 8'h00;
            pending_second_in = 8'h00;
            bytes_pending_in  = 2'd0;
            bytes_needed_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_lead_ff   <= 8'h00;
         pending_second_ff <= 8'h00;
         bytes_pending_ff  <= 2'd0;
         bytes_needed_ff   <= 2'd0;
      end else begin
         pending_lead_ff   <= pending_lead_in;
         pending_second_ff <= pending_second_in;
         bytes_pending_ff  <= bytes_pending_in;
         bytes_needed_ff   <= bytes_needed_in;
      end
   end

   // an open sequence always waits for at least one more byte
   a_open_needs: assert property (@(posedge clock) disable iff (reset)
      (bytes_pending_ff != 2'd0) |-> (bytes_needed_ff != 2'd0))
      else $error("open sequence with nothing needed");

   a_closed_clear: assert property (@(posedge clock) disable iff (reset)
      (bytes_pending_ff == 2'd0) |-> (bytes_needed_ff == 2'd0))
      else $error("closed sequence still needs bytes");

   // a last byte always leaves the decoder with no sequence open
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (bytes_pending_ff == 2'd0))
      else $error("sequence left open after last byte");

endmodule
`default_nettype wire

// ----- rtl/u2d_queue.sv -----
`default_nettype none
module u2d_queue import u2d_pkg::*; #(
   parameter int unsigned DEPTH = QueueDepthDefault
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          q_full,
   output logic          q_valid,
   output qent_type      q_entry
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   qent_type        slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push, do_pop;

   assign q_full  = (count_ff == FullCnt);
   assign q_valid = (count_ff != '0);
   assign q_entry = slots_ff[rd_ptr_ff];
   assign do_push = push.valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

// ----- rtl/u2d_back.sv -----
`default_nettype none
module u2d_back import u2d_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire qent_type q_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;
   logic    phase_ff,     phase_in;
   logic    out_free, load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = out_free && q_valid;
   // entry retires with its last character
   assign pop      = load && (phase_ff || !q_entry.has_second);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      if (out_free) begin
         rsp_valid_in = q_valid;
      end
      if (load) begin
         if (phase_ff) begin
            rsp_data_in.code_point    = {8'h00, q_entry.second_cp};
            rsp_data_in.end_of_string = 1'b1;
            phase_in                  = 1'b0;
         end else begin
            rsp_data_in.code_point    = q_entry.first_cp;
            rsp_data_in.end_of_string = q_entry.first_eos;
            phase_in                  = q_entry.has_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // second half pending means the first half is on the output
   a_phase_out: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> rsp_valid_ff)
      else $error("second character pending with output empty");

   a_phase_entry: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (q_valid && q_entry.has_second))
      else $error("second character pending without its entry");

   a_first_no_eos: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !rsp_data_ff.end_of_string)
      else $error("end of string flagged before second character");

endmodule
`default_nettype wire

// ----- rtl/utf8_to_ucs2_decoder_top.sv -----
// UTF-8 to UCS-2 stream decoder. Bytes arrive on req_ one per transfer, the
// final byte of each string flagged by is_last; 16-bit characters leave on
// rsp_. ASCII passes through, 110xxxxx leads join one more byte, 1110xxxx
// leads join two more (only the low six bits of following bytes are used,
// they are not checked). Stray continuation bytes and leads 0xF0 and up give
// '?' (0x3F). A lead cut off by the end of string gives '?'; if a three-byte
// sequence ends after its second byte, that byte is then decoded on its own.
// end_of_string marks the last character caused by the last byte; no
// sequence spans two strings. Throughput is one byte per clock: the front
// decoder keeps the open-sequence state and takes a byte every cycle while
// the queue has room. Each byte yields zero, one or two characters; the
// output register sends one character per cycle while rsp_stall is low;
// the extra character of a cut three-byte sequence waits in the queue
// (QUEUE_DEPTH entries), which sits before the output register.
`default_nettype none
module utf8_to_ucs2_decoder_top import u2d_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   push_type push;
   logic     q_full;
   logic     q_valid;
   qent_type q_entry;
   logic     pop;

   // front: sequence tracking and character assembly
   u2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .push      (push)
   );

   // decouples byte intake from character output
   u2d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_entry (q_entry)
   );

   // back: splits entries into characters, drives output register
   u2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
